>>> rtl/timed_keypad_code_lock_defines.svh
// Assertion helpers used by the lock core RTL.
`ifndef TIMED_KEYPAD_CODE_LOCK_DEFINES_SVH
`define TIMED_KEYPAD_CODE_LOCK_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define TKL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKL_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tkl_pkg.sv
package tkl_pkg;

	localparam int CODE_LENGTH    = 8;
	localparam int KEY_COUNT      = 16;
	localparam int DURATION_WIDTH = 16;

	localparam int OP_W      = 3;
	localparam int KEY_W     = 4;
	localparam int TICKS_W   = 16;
	localparam int TOL_W     = 16;
	localparam int ATT_W     = 2;
	localparam int STATUS_W  = 4;
	localparam int TONE_W    = 12;
	localparam int LED_W     = 8;
	localparam int LEFT_W    = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 16;

	localparam int POS_W     = $clog2(CODE_LENGTH);
	localparam int CNT_W     = $clog2(CODE_LENGTH + 1);
	localparam int KEY_CNT_W = KEY_W + 1;
	localparam int CMP_W     = (DURATION_WIDTH > TICKS_W) ? DURATION_WIDTH : TICKS_W;

	localparam logic [TOL_W-1:0]  TOL_RESET  = TOL_W'(20);
	localparam logic [ATT_W-1:0]  ATT_RESET  = ATT_W'(3);
	localparam logic [TONE_W-1:0] TONE_ERROR = TONE_W'(3100);
	localparam logic [LED_W-1:0]  LED_ALL    = '1;

	typedef enum logic [OP_W-1:0] {
		OP_KEY          = 3'd0,
		OP_START_SET    = 3'd1,
		OP_SAVE         = 3'd2,
		OP_RETRY        = 3'd3,
		OP_START_UNLOCK = 3'd4,
		OP_RELOCK       = 3'd5
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_IGNORED       = 4'd0,
		ST_KEY_STORED    = 4'd1,
		ST_CODE_COMPLETE = 4'd2,
		ST_SAVED         = 4'd3,
		ST_RETRY         = 4'd4,
		ST_KEY_MATCHED   = 4'd5,
		ST_WRONG         = 4'd6,
		ST_LOCKOUT       = 4'd7,
		ST_UNLOCKED      = 4'd8,
		ST_RELOCKED      = 4'd9,
		ST_ENTRY_STARTED = 4'd10
	} status_t;

	typedef enum logic [2:0] {
		M_NOCODE   = 3'd0,
		M_SETTING  = 3'd1,
		M_CONFIRM  = 3'd2,
		M_LOCKED   = 3'd3,
		M_ENTRY    = 3'd4,
		M_UNLOCKED = 3'd5,
		M_LOCKOUT  = 3'd6
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TOLERANCE    = 1'b0,
		CFG_MAX_ATTEMPTS = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [KEY_W-1:0]   key_code;
		logic [TICKS_W-1:0] press_ticks;
	} evt_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TONE_W-1:0]   tone_period;
		logic [LED_W-1:0]    led_pattern;
		logic [ATT_W-1:0]    attempts_left;
		logic [LEFT_W-1:0]   entries_left;
	} rsp_t;

	typedef struct packed {
		logic [TOL_W-1:0] tolerance;
		logic [ATT_W-1:0] max_attempts;
	} cfg_t;

	function automatic logic [TONE_W-1:0] note_period(input logic [KEY_W-1:0] key);
		logic [TONE_W-1:0] p;
		unique case (key)
			4'd0:  p = TONE_W'(2554);
			4'd1:  p = TONE_W'(853);
			4'd2:  p = TONE_W'(760);
			4'd3:  p = TONE_W'(717);
			4'd4:  p = TONE_W'(1277);
			4'd5:  p = TONE_W'(1138);
			4'd6:  p = TONE_W'(1074);
			4'd7:  p = TONE_W'(1914);
			4'd8:  p = TONE_W'(1705);
			4'd9:  p = TONE_W'(1519);
			4'd10: p = TONE_W'(639);
			4'd11: p = TONE_W'(957);
			4'd12: p = TONE_W'(1434);
			4'd13: p = TONE_W'(2148);
			4'd14: p = TONE_W'(2867);
			4'd15: p = TONE_W'(2276);
			default: p = '0;
		endcase
		return p;
	endfunction

	// Mask with the n lowest LED bits set; saturates at all ones.
	function automatic logic [LED_W-1:0] low_ones(input int unsigned n);
		logic [LED_W-1:0] m;
		for (int i = 0; i < LED_W; i++) begin
			m[i] = (n > i);
		end
		return m;
	endfunction

	function automatic logic [DURATION_WIDTH-1:0] clip_ticks(input logic [TICKS_W-1:0] t);
		logic [CMP_W-1:0] tw;
		logic [CMP_W-1:0] maxv;
		tw   = CMP_W'(t);
		maxv = CMP_W'({DURATION_WIDTH{1'b1}});
		return (tw > maxv) ? {DURATION_WIDTH{1'b1}} : DURATION_WIDTH'(tw);
	endfunction

endpackage

>>> rtl/tkl_event_if.sv
interface tkl_event_if;
	logic                         valid;
	logic                         ready;
	logic [tkl_pkg::OP_W-1:0]    opcode;
	logic [tkl_pkg::KEY_W-1:0]   key_code;
	logic [tkl_pkg::TICKS_W-1:0] press_ticks;

	modport source (output valid, opcode, key_code, press_ticks, input ready);
	modport sink (input valid, opcode, key_code, press_ticks, output ready);
endinterface

>>> rtl/tkl_result_if.sv
interface tkl_result_if;
	logic                          valid;
	logic                          ready;
	logic [tkl_pkg::STATUS_W-1:0] status;
	logic [tkl_pkg::TONE_W-1:0]   tone_period;
	logic [tkl_pkg::LED_W-1:0]    led_pattern;
	logic [tkl_pkg::ATT_W-1:0]    attempts_left;
	logic [tkl_pkg::LEFT_W-1:0]   entries_left;

	modport source (output valid, status, tone_period, led_pattern, attempts_left,
		entries_left, input ready);
	modport sink (input valid, status, tone_period, led_pattern, attempts_left,
		entries_left, output ready);
endinterface

>>> rtl/tkl_cfg_regs.sv
module tkl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tkl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tkl_pkg::CFG_DAT_W-1:0] cfg_wdata,
	output tkl_pkg::cfg_t                  cfg
);

	logic [tkl_pkg::TOL_W-1:0] tolerance_q;
	logic [tkl_pkg::ATT_W-1:0] max_attempts_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q    <= tkl_pkg::TOL_RESET;
			max_attempts_q <= tkl_pkg::ATT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tkl_pkg::CFG_TOLERANCE: begin
					tolerance_q <= tkl_pkg::TOL_W'(cfg_wdata);
				end
				tkl_pkg::CFG_MAX_ATTEMPTS: begin
					max_attempts_q <= cfg_wdata[tkl_pkg::ATT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.tolerance    = tolerance_q;
	assign cfg.max_attempts = max_attempts_q;

endmodule

>>> rtl/tkl_lock_core.sv
`include "timed_keypad_code_lock_defines.svh"

module tkl_lock_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  tkl_pkg::evt_t  evt,
	input  tkl_pkg::cfg_t  cfg,
	output tkl_pkg::rsp_t  rsp
);

	tkl_pkg::mode_t mode_q, mode_d;
	logic [tkl_pkg::POS_W-1:0] pos_q, pos_d;
	logic [tkl_pkg::ATT_W-1:0] att_q, att_d;
	logic [tkl_pkg::LED_W-1:0] led_q, led_d;

	// Stored code; contents are only read after a full set sequence wrote them.
	logic [tkl_pkg::KEY_W-1:0]          key_mem [tkl_pkg::CODE_LENGTH];
	logic [tkl_pkg::DURATION_WIDTH-1:0] dur_mem [tkl_pkg::CODE_LENGTH];
	logic mem_we;

	logic [tkl_pkg::CNT_W-1:0]          pos_inc;
	logic                               code_done;
	logic [tkl_pkg::DURATION_WIDTH-1:0] ticks;
	logic [tkl_pkg::CMP_W-1:0]          dur_a, dur_b, dur_diff;
	logic                               key_ok, match;
	logic [tkl_pkg::ATT_W-1:0]          att_dec;
	logic [tkl_pkg::TONE_W-1:0]         note;
	tkl_pkg::status_t                   status;
	logic [tkl_pkg::TONE_W-1:0]         tone;

	assign pos_inc   = tkl_pkg::CNT_W'(pos_q) + tkl_pkg::CNT_W'(1);
	assign code_done = (pos_inc == tkl_pkg::CNT_W'(tkl_pkg::CODE_LENGTH));
	assign ticks     = tkl_pkg::clip_ticks(evt.press_ticks);
	assign dur_a     = tkl_pkg::CMP_W'(dur_mem[pos_q]);
	assign dur_b     = tkl_pkg::CMP_W'(ticks);
	assign dur_diff  = (dur_a > dur_b) ? (dur_a - dur_b) : (dur_b - dur_a);
	assign key_ok    = tkl_pkg::KEY_CNT_W'(evt.key_code) <
		tkl_pkg::KEY_CNT_W'(tkl_pkg::KEY_COUNT);
	assign match     = (key_mem[pos_q] == evt.key_code) &&
		(dur_diff <= tkl_pkg::CMP_W'(cfg.tolerance));
	assign att_dec   = (att_q != '0) ? (att_q - tkl_pkg::ATT_W'(1)) : '0;
	assign note      = tkl_pkg::note_period(evt.key_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= tkl_pkg::M_NOCODE;
		end else if (go) begin
			mode_q <= mode_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			att_q <= tkl_pkg::ATT_RESET;
			led_q <= '0;
		end else if (go) begin
			pos_q <= pos_d;
			att_q <= att_d;
			led_q <= led_d;
		end
	end

	always_ff @(posedge clk) begin
		if (go && mem_we) begin
			key_mem[pos_q] <= evt.key_code;
			dur_mem[pos_q] <= ticks;
		end
	end

	always_comb begin
		mode_d = mode_q;
		pos_d  = pos_q;
		att_d  = att_q;
		led_d  = led_q;
		mem_we = 1'b0;
		status = tkl_pkg::ST_IGNORED;
		tone   = '0;
		unique case (evt.opcode)
			tkl_pkg::OP_KEY: begin
				if (key_ok && mode_q == tkl_pkg::M_SETTING) begin
					mem_we = 1'b1;
					pos_d  = tkl_pkg::POS_W'(pos_inc);
					led_d  = led_q & tkl_pkg::low_ones(tkl_pkg::CODE_LENGTH - int'(pos_inc));
					tone   = note;
					if (code_done) begin
						mode_d = tkl_pkg::M_CONFIRM;
						status = tkl_pkg::ST_CODE_COMPLETE;
					end else begin
						status = tkl_pkg::ST_KEY_STORED;
					end
				end else if (key_ok && mode_q == tkl_pkg::M_ENTRY) begin
					if (match) begin
						tone  = note;
						pos_d = tkl_pkg::POS_W'(pos_inc);
						if (code_done) begin
							mode_d = tkl_pkg::M_UNLOCKED;
							pos_d  = '0;
							att_d  = cfg.max_attempts;
							led_d  = '0;
							status = tkl_pkg::ST_UNLOCKED;
						end else begin
							status = tkl_pkg::ST_KEY_MATCHED;
						end
					end else begin
						// A miss restarts entry at the first key and costs one attempt.
						tone  = tkl_pkg::TONE_ERROR;
						pos_d = '0;
						att_d = att_dec;
						if (att_dec == '0) begin
							mode_d = tkl_pkg::M_LOCKOUT;
							led_d  = '0;
							status = tkl_pkg::ST_LOCKOUT;
						end else begin
							led_d  = led_q & tkl_pkg::low_ones(int'(att_dec));
							status = tkl_pkg::ST_WRONG;
						end
					end
				end
			end
			tkl_pkg::OP_START_SET: begin
				if (mode_q == tkl_pkg::M_NOCODE || mode_q == tkl_pkg::M_UNLOCKED) begin
					mode_d = tkl_pkg::M_SETTING;
					pos_d  = '0;
					led_d  = tkl_pkg::LED_ALL;
					status = tkl_pkg::ST_ENTRY_STARTED;
				end
			end
			tkl_pkg::OP_SAVE: begin
				if (mode_q == tkl_pkg::M_CONFIRM) begin
					mode_d = tkl_pkg::M_LOCKED;
					pos_d  = '0;
					att_d  = cfg.max_attempts;
					status = tkl_pkg::ST_SAVED;
				end
			end
			tkl_pkg::OP_RETRY: begin
				if (mode_q == tkl_pkg::M_CONFIRM) begin
					mode_d = tkl_pkg::M_SETTING;
					pos_d  = '0;
					led_d  = tkl_pkg::LED_ALL;
					status = tkl_pkg::ST_RETRY;
				end
			end
			tkl_pkg::OP_START_UNLOCK: begin
				if (mode_q == tkl_pkg::M_LOCKED && att_q != '0) begin
					mode_d = tkl_pkg::M_ENTRY;
					pos_d  = '0;
					led_d  = tkl_pkg::low_ones(int'(att_q));
					status = tkl_pkg::ST_ENTRY_STARTED;
				end
			end
			tkl_pkg::OP_RELOCK: begin
				if (mode_q == tkl_pkg::M_UNLOCKED) begin
					mode_d = tkl_pkg::M_LOCKED;
					pos_d  = '0;
					status = tkl_pkg::ST_RELOCKED;
				end
			end
			default: begin
			end
		endcase

		rsp.status        = status;
		rsp.tone_period   = tone;
		rsp.led_pattern   = led_d;
		rsp.attempts_left = att_d;
		if (mode_d == tkl_pkg::M_SETTING || mode_d == tkl_pkg::M_ENTRY) begin
			rsp.entries_left = tkl_pkg::LEFT_W'(tkl_pkg::CNT_W'(tkl_pkg::CODE_LENGTH) -
				tkl_pkg::CNT_W'(pos_d));
		end else begin
			rsp.entries_left = '0;
		end
	end

	`TKL_ASSERT_NXT(a_lockout_sticky, clk, arst_n, mode_q == tkl_pkg::M_LOCKOUT, mode_q == tkl_pkg::M_LOCKOUT, "lockout left")
	`TKL_ASSERT_IMP(a_lockout_quiet, clk, arst_n, go && mode_q == tkl_pkg::M_LOCKOUT, rsp.status == tkl_pkg::ST_IGNORED, "event honored in lockout")
	`TKL_ASSERT_NXT(a_miss_costs, clk, arst_n, go && rsp.status == tkl_pkg::ST_WRONG, att_q == $past(att_q) - 2'd1, "miss did not cost an attempt")
	`TKL_ASSERT_NXT(a_unlock_clear, clk, arst_n, go && rsp.status == tkl_pkg::ST_UNLOCKED, led_q == '0 && pos_q == '0, "unlock left state")

endmodule

>>> rtl/timed_keypad_code_lock.sv
// Timed keypad code lock. One event transaction is accepted per clock cycle while the event
// channel does not stall. The event is captured in an input register. The lock state (mode,
// entry position, attempts, LED bits and the stored eight-key code with press durations) is
// compared and updated as the event leaves the input register. The result is then held in an
// output register, from which the single result transaction is offered. While that result
// waits to be taken, one more event can wait in the input register; after that the event
// channel stalls until the result is taken. The rate is set by the state update loop in the
// lock core. Configuration has two registers. The tolerance is at index 0 and is used by the
// next compare. The attempt limit is at index 1 and is loaded at the next save or unlock.
// Make configuration writes only while no event is in flight.
module timed_keypad_code_lock (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tkl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tkl_pkg::CFG_DAT_W-1:0] cfg_wdata,
	tkl_event_if.sink                      evt,
	tkl_result_if.source                   res
);

	tkl_pkg::cfg_t cfg;
	tkl_pkg::evt_t evt_s1;
	logic          valid_s1;
	tkl_pkg::rsp_t rsp;
	tkl_pkg::rsp_t rsp_s2;
	logic          valid_s2;
	logic          go;

	// The staged event advances when the output register is empty or being drained.
	assign go        = valid_s1 && (!valid_s2 || res.ready);
	assign evt.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (evt.ready) begin
			valid_s1 <= evt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (evt.ready && evt.valid) begin
			evt_s1.opcode      <= evt.opcode;
			evt_s1.key_code    <= evt.key_code;
			evt_s1.press_ticks <= evt.press_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_s2 <= rsp;
		end
	end

	tkl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	tkl_lock_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.evt    (evt_s1),
		.cfg    (cfg),
		.rsp    (rsp)
	);

	assign res.valid         = valid_s2;
	assign res.status        = rsp_s2.status;
	assign res.tone_period   = rsp_s2.tone_period;
	assign res.led_pattern   = rsp_s2.led_pattern;
	assign res.attempts_left = rsp_s2.attempts_left;
	assign res.entries_left  = rsp_s2.entries_left;

endmodule
